// ----- rtl/assert_macros.svh -----
// Assertion macros for the buddy page allocator RTL, used by the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check, held off during reset.
`define BPA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bpa assertion failed");
// Implication check, held off during reset.
`define BPA_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bpa implication failed");
`else
`define BPA_ASSERT(name, clk, rst, prop)
`define BPA_ASSERT_IMP(name, clk, rst, pre, post)
`endif
`endif

// ----- rtl/bpa_pkg.sv -----
// Package: constants, codes and controller/datapath types of the buddy page allocator.
`default_nettype none
package bpa_pkg;
   localparam int PAGE_AW     = 15;
   localparam int MAX_PAGES   = 32768;
   localparam int NUM_ORDERS  = 11;
   localparam int TOP_ORDER   = 10;
   localparam int ORD_W       = 4;
   localparam int CNT_W       = 16;
   localparam int TB_W        = 2;
   localparam int SPAN_W      = TB_W + TOP_ORDER;
   localparam int COUNT_W     = 11;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int CSR_DW      = 16;
   localparam int CSR_IW      = 1;
   localparam int TB_RESET    = 2;
   localparam int TOTAL_RESET = 31929;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_INIT  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_BADFREE = 2'd2
   } status_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_TOP_BLOCKS  = 1'd0,
      CSR_TOTAL_PAGES = 1'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      S_RCLR_START,
      S_RCLR,
      S_IDLE,
      S_DISPATCH,
      S_ICLR_START,
      S_ICLR,
      S_BUILD_START,
      S_BUILD,
      S_ALLOC,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SPLIT,
      S_FREE_RD,
      S_FREE_CHK,
      S_BUD_RD,
      S_BUD_CHK,
      S_RESULT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_CLR_START,
      DP_CLR_STEP,
      DP_BUILD_START,
      DP_BUILD,
      DP_ALLOC_PICK,
      DP_SCAN_ADV,
      DP_ALLOC_TAKE,
      DP_SPLIT,
      DP_FREE_CLR,
      DP_BUD_RD,
      DP_BUD_MERGE,
      DP_PUT,
      DP_RESULT
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     m_big;
      logic     k_none;
      logic     q_match;
      logic     q_alloc;
      logic     scan_last;
      logic     split_done;
      logic     k_top;
      logic     clr_last;
      logic     build_done;
   } stat_type;

   typedef struct packed {
      logic             is_free;
      logic             is_alloc;
      logic [ORD_W-1:0] order;
   } mem_word_type;
endpackage
`default_nettype wire

// ----- rtl/bpa_if.sv -----
// Request and response channel interfaces of the buddy page allocator.
`default_nettype none
interface bpa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::MODE_W-1:0]   mode;
   logic [bpa_pkg::COUNT_W-1:0]  page_count;
   logic [bpa_pkg::PAGE_AW-1:0]  page_address;
   modport source (output valid, mode, page_count, page_address, input ready);
   modport sink (input valid, mode, page_count, page_address, output ready);
endinterface

interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::PAGE_AW-1:0]   block_address;
   logic [bpa_pkg::CNT_W-1:0]     free_total;
   modport source (output valid, status, block_address, free_total, input ready);
   modport sink (input valid, status, block_address, free_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/buddy_page_allocator.sv -----
// Top level: buddy page allocator, controller plus datapath over a page map memory.
// Allocate checks the order, reads and checks each probed block, splits and responds. Free
// reads and checks the head (a bad free responds there), merges with free buddies up to
// order 10, puts the block and responds. Init clears the map, builds blocks and responds.
// One request at a time; the next can be taken in the cycle after the response is issued.
// After reset a clearing pass runs with req ready low; csr writes taken.
`default_nettype none
module buddy_page_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bpa_req_if.sink                            req_bus,
   bpa_rsp_if.source                          rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [bpa_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [bpa_pkg::CSR_DW-1:0]    csr_wdata
);
   import bpa_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;
   logic     rsp_valid;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // request fields are sampled by the datapath on the accepting edge
   bpa_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_bus.mode),
      .req_page_count    (req_bus.page_count),
      .req_page_address  (req_bus.page_address),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_bus.status),
      .rsp_block_address (rsp_bus.block_address),
      .rsp_free_total    (rsp_bus.free_total)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;
endmodule
`default_nettype wire

// ----- rtl/bpa_dp.sv -----
// Datapath: page map memory, per-order counters, cursors and response registers.
`default_nettype none
`include "assert_macros.svh"
module bpa_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bpa_pkg::cmd_type              cmd,
   output      bpa_pkg::stat_type             stat,
   input  wire logic [bpa_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [bpa_pkg::COUNT_W-1:0]   req_page_count,
   input  wire logic [bpa_pkg::PAGE_AW-1:0]   req_page_address,
   input  wire logic                          csr_we,
   input  wire logic [bpa_pkg::CSR_IW-1:0]    csr_index,
   input  wire logic [bpa_pkg::CSR_DW-1:0]    csr_wdata,
   output      logic [bpa_pkg::STATUS_W-1:0]  rsp_status,
   output      logic [bpa_pkg::PAGE_AW-1:0]   rsp_block_address,
   output      logic [bpa_pkg::CNT_W-1:0]     rsp_free_total
);
   import bpa_pkg::*;

   mem_word_type mem [MAX_PAGES];
   mem_word_type mem_q;

   logic [TB_W-1:0]    cfg_tb_ff;
   logic [CNT_W-1:0]   cfg_total_ff;
   mode_type           mode_ff;
   logic [ORD_W-1:0]   m_ff, m_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [ORD_W-1:0]   k_ff, k_in;
   logic [SPAN_W-1:0]  j_ff, j_in;
   logic [ORD_W-1:0]   sp_ff, sp_in;
   logic [PAGE_AW-1:0] blk_ff, blk_in;
   logic [CNT_W-1:0]   cnt_ff [NUM_ORDERS];
   logic [CNT_W-1:0]   total_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAGE_AW-1:0]  rsp_block_ff;
   logic [CNT_W-1:0]    rsp_total_ff;

   logic [NUM_ORDERS-1:0] nz;
   logic [ORD_W-1:0]   pick;
   logic               none;
   logic [COUNT_W-1:0] c1;
   logic [CNT_W-1:0]   step;
   logic [PAGE_AW-1:0] buddy;
   logic [CNT_W:0]     sum17;
   logic [CNT_W-1:0]   limit;
   logic [SPAN_W-1:0]  nblk;
   logic               blk_fit, one_fit, q_match;
   logic               wr_en;
   logic [PAGE_AW-1:0] wr_addr, rd_addr;
   mem_word_type       wr_data;
   logic               cnt_en, cnt_inc, cnt_clr;
   logic [ORD_W-1:0]   cnt_idx;

   always_comb begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
         nz[i] = (cnt_ff[i] != '0);
      end
      pick = '0;
      none = 1'b1;
      // lowest order at or above m that holds a free block
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         if (nz[i] && (ORD_W'(i) >= m_ff)) begin
            pick = ORD_W'(i);
            none = 1'b0;
         end
      end
   end

   // order needed for the requested count: ceil(log2(count)), zero count as one
   always_comb begin
      c1 = (req_page_count == '0) ? '0 : req_page_count - 1'b1;
      m_in = '0;
      for (int i = 0; i < COUNT_W; i++) begin
         if ((c1 >> i) != '0) begin
            m_in = ORD_W'(i + 1);
         end
      end
   end

   assign step    = CNT_W'(1) << k_ff;
   assign buddy   = addr_ff[PAGE_AW-1:0] ^ step[PAGE_AW-1:0];
   assign sum17   = {1'b0, addr_ff} + {1'b0, step};
   assign limit   = (cfg_total_ff > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_total_ff;
   assign nblk    = SPAN_W'({cfg_tb_ff, {TOP_ORDER{1'b0}}}) >> k_ff;
   assign blk_fit = (k_ff != '0) && (j_ff < nblk) && (sum17 <= {1'b0, limit});
   assign one_fit = (addr_ff < limit);
   assign q_match = mem_q.is_free && (mem_q.order == k_ff);

   assign stat.mode       = mode_ff;
   assign stat.m_big      = (m_ff > ORD_W'(TOP_ORDER));
   assign stat.k_none     = none;
   assign stat.q_match    = q_match;
   assign stat.q_alloc    = mem_q.is_alloc;
   assign stat.scan_last  = (sum17 >= (CNT_W + 1)'(MAX_PAGES));
   assign stat.split_done = (sp_ff == k_ff);
   assign stat.k_top      = (k_ff == ORD_W'(TOP_ORDER));
   assign stat.clr_last   = (addr_ff[PAGE_AW-1:0] == '1);
   assign stat.build_done = (k_ff == '0) && !one_fit;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff[PAGE_AW-1:0];
      wr_data = '0;
      rd_addr = addr_ff[PAGE_AW-1:0];
      cnt_en  = 1'b0;
      cnt_inc = 1'b1;
      cnt_idx = k_ff;
      cnt_clr = 1'b0;
      addr_in = addr_ff;
      k_in    = k_ff;
      j_in    = j_ff;
      sp_in   = sp_ff;
      blk_in  = blk_ff;
      case (cmd.op)
         DP_CAPTURE: begin
            addr_in = {1'b0, req_page_address};
            blk_in  = '0;
         end
         DP_CLR_START: begin
            addr_in = '0;
            cnt_clr = 1'b1;
         end
         DP_CLR_STEP: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + 1'b1;
         end
         DP_BUILD_START: begin
            addr_in = '0;
            k_in    = ORD_W'(TOP_ORDER);
            j_in    = '0;
         end
         DP_BUILD: begin
            if (k_ff != '0) begin
               if (blk_fit) begin
                  wr_en   = 1'b1;
                  wr_data = '{is_free: 1'b1, is_alloc: 1'b0, order: k_ff};
                  cnt_en  = 1'b1;
                  addr_in = sum17[CNT_W-1:0];
                  j_in    = j_ff + 1'b1;
               end else begin
                  k_in = k_ff - 1'b1;
                  j_in = '0;
               end
            end else if (one_fit) begin
               wr_en   = 1'b1;
               wr_data = '{is_free: 1'b1, is_alloc: 1'b0, order: '0};
               cnt_en  = 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         DP_ALLOC_PICK: begin
            k_in    = pick;
            addr_in = '0;
         end
         DP_SCAN_ADV: begin
            addr_in = sum17[CNT_W-1:0];
         end
         DP_ALLOC_TAKE: begin
            wr_en   = 1'b1;
            wr_data = '{is_free: 1'b0, is_alloc: 1'b1, order: m_ff};
            cnt_en  = 1'b1;
            cnt_inc = 1'b0;
            blk_in  = addr_ff[PAGE_AW-1:0];
            sp_in   = m_ff;
         end
         DP_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = addr_ff[PAGE_AW-1:0] + (PAGE_AW'(1) << sp_ff);
            wr_data = '{is_free: 1'b1, is_alloc: 1'b0, order: sp_ff};
            cnt_en  = 1'b1;
            cnt_idx = sp_ff;
            sp_in   = sp_ff + 1'b1;
         end
         DP_FREE_CLR: begin
            wr_en   = 1'b1;
            wr_data = '{is_free: 1'b0, is_alloc: 1'b0, order: mem_q.order};
            k_in    = (mem_q.order > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : mem_q.order;
         end
         DP_BUD_RD: begin
            rd_addr = buddy;
         end
         DP_BUD_MERGE: begin
            wr_en   = 1'b1;
            wr_addr = buddy;
            wr_data = '{is_free: 1'b0, is_alloc: 1'b0, order: k_ff};
            cnt_en  = 1'b1;
            cnt_inc = 1'b0;
            addr_in = addr_ff & ~step;
            k_in    = k_ff + 1'b1;
         end
         DP_PUT: begin
            wr_en   = 1'b1;
            wr_data = '{is_free: 1'b1, is_alloc: 1'b0, order: k_ff};
            cnt_en  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_tb_ff    <= TB_W'(TB_RESET);
         cfg_total_ff <= CNT_W'(TOTAL_RESET);
         total_ff     <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            cnt_ff[i] <= '0;
         end
         addr_ff <= '0;
         k_ff    <= '0;
         j_ff    <= '0;
         sp_ff   <= '0;
         blk_ff  <= '0;
         mode_ff <= MODE_NONE;
         m_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_TOP_BLOCKS:  cfg_tb_ff    <= csr_wdata[TB_W-1:0];
               CSR_TOTAL_PAGES: cfg_total_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cnt_clr) begin
            total_ff <= '0;
            for (int i = 0; i < NUM_ORDERS; i++) begin
               cnt_ff[i] <= '0;
            end
         end else if (cnt_en) begin
            total_ff <= cnt_inc ? total_ff + (CNT_W'(1) << cnt_idx)
                                : total_ff - (CNT_W'(1) << cnt_idx);
            for (int i = 0; i < NUM_ORDERS; i++) begin
               if (cnt_idx == ORD_W'(i)) begin
                  cnt_ff[i] <= cnt_inc ? cnt_ff[i] + 1'b1 : cnt_ff[i] - 1'b1;
               end
            end
         end
         if (cmd.op == DP_CAPTURE) begin
            mode_ff <= mode_type'(req_mode);
            m_ff    <= m_in;
         end
         addr_ff <= addr_in;
         k_ff    <= k_in;
         j_ff    <= j_in;
         sp_ff   <= sp_in;
         blk_ff  <= blk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_RESULT) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_block_ff  <= (cmd.rsp_status == STAT_OK) ? blk_ff : '0;
         rsp_total_ff  <= total_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_block_ff;
   assign rsp_free_total    = rsp_total_ff;

   `BPA_ASSERT(a_total_bound, clock, reset, total_ff <= CNT_W'(MAX_PAGES))
   `BPA_ASSERT_IMP(a_take_nonempty, clock, reset, cmd.op == DP_ALLOC_TAKE, nz[k_ff])
   `BPA_ASSERT_IMP(a_split_below, clock, reset, cmd.op == DP_SPLIT, sp_ff < k_ff)
   `BPA_ASSERT_IMP(a_merge_below_top, clock, reset, cmd.op == DP_BUD_MERGE,
                   k_ff < ORD_W'(TOP_ORDER))
endmodule
`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
// Controller: sequences clear, build, allocate search/split and free/merge steps.
`default_nettype none
module bpa_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire bpa_pkg::stat_type  stat,
   output      bpa_pkg::cmd_type   cmd
);
   import bpa_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RCLR_START;
         code_ff      <= STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd.op         = DP_NOP;
      cmd.rsp_status = code_ff;
      req_ready      = 1'b0;
      case (state_ff)
         S_RCLR_START: begin
            cmd.op   = DP_CLR_START;
            state_in = S_RCLR;
         end
         S_RCLR: begin
            cmd.op = DP_CLR_STEP;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_CAPTURE;
               code_in  = STAT_OK;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ALLOC: state_in = S_ALLOC;
               MODE_FREE:  state_in = S_FREE_RD;
               MODE_INIT:  state_in = S_ICLR_START;
               default:    state_in = S_RESULT;
            endcase
         end
         S_ICLR_START: begin
            cmd.op   = DP_CLR_START;
            state_in = S_ICLR;
         end
         S_ICLR: begin
            cmd.op = DP_CLR_STEP;
            if (stat.clr_last) begin
               state_in = S_BUILD_START;
            end
         end
         S_BUILD_START: begin
            cmd.op   = DP_BUILD_START;
            state_in = S_BUILD;
         end
         S_BUILD: begin
            if (stat.build_done) begin
               state_in = S_RESULT;
            end else begin
               cmd.op = DP_BUILD;
            end
         end
         S_ALLOC: begin
            if (stat.m_big || stat.k_none) begin
               code_in  = STAT_NOSPACE;
               state_in = S_RESULT;
            end else begin
               cmd.op   = DP_ALLOC_PICK;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (stat.q_match) begin
               cmd.op   = DP_ALLOC_TAKE;
               state_in = S_SPLIT;
            end else if (stat.scan_last) begin
               code_in  = STAT_NOSPACE;
               state_in = S_RESULT;
            end else begin
               cmd.op   = DP_SCAN_ADV;
               state_in = S_SCAN_RD;
            end
         end
         S_SPLIT: begin
            if (stat.split_done) begin
               state_in = S_RESULT;
            end else begin
               cmd.op = DP_SPLIT;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_CHK;
         end
         S_FREE_CHK: begin
            if (!stat.q_alloc) begin
               code_in  = STAT_BADFREE;
               state_in = S_RESULT;
            end else begin
               cmd.op   = DP_FREE_CLR;
               state_in = S_BUD_RD;
            end
         end
         S_BUD_RD: begin
            if (stat.k_top) begin
               cmd.op   = DP_PUT;
               state_in = S_RESULT;
            end else begin
               cmd.op   = DP_BUD_RD;
               state_in = S_BUD_CHK;
            end
         end
         S_BUD_CHK: begin
            if (stat.q_match) begin
               cmd.op   = DP_BUD_MERGE;
               state_in = S_BUD_RD;
            end else begin
               cmd.op   = DP_PUT;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ----- bench/bpa_checker.sv -----
// Checker for the buddy page allocator: predicts every response and compares it field by field.
`timescale 1ns / 1ps
module bpa_checker (
   input  logic                         clock,
   input  logic                         reset,
   bpa_req_if                           req,
   bpa_rsp_if                           rsp,
   input  logic                         csr_we,
   input  logic [bpa_pkg::CSR_IW-1:0]   csr_index,
   input  logic [bpa_pkg::CSR_DW-1:0]   csr_wdata,
   output int                           fail_count,
   output int                           pending,
   output int                           checked
);
   import bpa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_AW-1:0]  block;
      logic [CNT_W-1:0]    total;
   } page_result_type;

   bit               free_head [MAX_PAGES];
   logic [ORD_W-1:0] head_ord  [MAX_PAGES];
   bit               alloc_head[MAX_PAGES];
   int unsigned      order_pages[NUM_ORDERS];
   logic [TB_W-1:0]  cfg_top;
   logic [CNT_W-1:0] cfg_total;
   page_result_type  expected_q[$];
   int               errors;
   int               matched;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      errors     = 0;
      matched    = 0;
   end

   function automatic void wipe_pool();
      for (int i = 0; i < MAX_PAGES; i++) begin
         free_head[i]  = 1'b0;
         head_ord[i]   = '0;
         alloc_head[i] = 1'b0;
      end
      for (int k = 0; k < NUM_ORDERS; k++) order_pages[k] = 0;
   endfunction

   function automatic void add_free(int unsigned a, int unsigned k);
      free_head[a] = 1'b1;
      head_ord[a]  = k[ORD_W-1:0];
      order_pages[k] += 1 << k;
   endfunction

   function automatic logic [CNT_W-1:0] pages_free();
      int unsigned s;
      s = 0;
      for (int k = 0; k < NUM_ORDERS; k++) s += order_pages[k];
      return (s > 65535) ? 16'hFFFF : s[CNT_W-1:0];
   endfunction

   // regions from the top order down, then single pages up to the end of the pool
   function automatic void build_pool();
      int unsigned lim, cursor, region, n;
      lim    = (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
      cursor = 0;
      region = cfg_top * 1024;
      wipe_pool();
      for (int k = TOP_ORDER; k >= 1; k--) begin
         n = region >> k;
         for (int j = 0; j < n; j++) begin
            if (cursor + (1 << k) > lim) break;
            add_free(cursor, k);
            cursor += 1 << k;
         end
      end
      for (; cursor < lim; cursor++) add_free(cursor, 0);
   endfunction

   function automatic page_result_type serve(logic [MODE_W-1:0] mode,
                                             logic [COUNT_W-1:0] cnt_in,
                                             logic [PAGE_AW-1:0] addr);
      page_result_type r;
      int unsigned     cnt, m, k, a, b;
      bit              found;
      r.status = STAT_OK;
      r.block  = '0;
      case (mode)
         MODE_ALLOC: begin
            cnt = (cnt_in == 0) ? 1 : cnt_in;
            m = 0;
            while (m < 16 && (1 << m) < cnt) m++;
            if (m >= NUM_ORDERS) begin
               r.status = STAT_NOSPACE;
            end else begin
               k = m;
               while (k < NUM_ORDERS && order_pages[k] == 0) k++;
               found = 1'b0;
               a = 0;
               if (k < NUM_ORDERS) begin
                  for (a = 0; a < MAX_PAGES; a += (1 << k)) begin
                     if (free_head[a] && head_ord[a] == k) begin
                        found = 1'b1;
                        break;
                     end
                  end
               end
               if (!found) begin
                  r.status = STAT_NOSPACE;
               end else begin
                  free_head[a] = 1'b0;
                  order_pages[k] -= 1 << k;
                  alloc_head[a] = 1'b1;
                  head_ord[a] = m[ORD_W-1:0];
                  for (int unsigned j = m; j < k; j++) add_free(a + (1 << j), j);
                  r.block = a[PAGE_AW-1:0];
               end
            end
         end
         MODE_FREE: begin
            if (!alloc_head[addr]) begin
               r.status = STAT_BADFREE;
            end else begin
               k = head_ord[addr];
               a = addr;
               alloc_head[addr] = 1'b0;
               if (k > TOP_ORDER) k = TOP_ORDER;
               // merge upward, never past the top order
               while (k < TOP_ORDER) begin
                  b = a ^ (1 << k);
                  if (b >= MAX_PAGES || !free_head[b] || head_ord[b] != k) break;
                  free_head[b] = 1'b0;
                  order_pages[k] -= 1 << k;
                  a &= ~(1 << k);
                  k++;
               end
               add_free(a, k);
            end
         end
         MODE_INIT: build_pool();
         default: ;
      endcase
      r.total = pages_free();
      return r;
   endfunction

   task automatic flag(string what, int got, int want);
      errors++;
      $display("checker: %s got %0d want %0d", what, got, want);
   endtask

   always @(posedge clock) begin
      page_result_type want;
      if (reset) begin
         cfg_top   = TB_W'(TB_RESET);
         cfg_total = CNT_W'(TOTAL_RESET);
         wipe_pool();
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TOP_BLOCKS:  cfg_top   = csr_wdata[TB_W-1:0];
               CSR_TOTAL_PAGES: cfg_total = csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            expected_q.push_back(serve(req.mode, req.page_count, req.page_address));
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               flag("response with no request waiting", rsp.status, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp.status !== want.status) flag("status", rsp.status, want.status);
               if (rsp.block_address !== want.block)
                  flag("block_address", rsp.block_address, want.block);
               if (rsp.free_total !== want.total)
                  flag("free_total", rsp.free_total, want.total);
               matched++;
            end
         end
      end
      fail_count <= errors;
      pending    <= expected_q.size();
      checked    <= matched;
   end
endmodule

// ----- bench/testbench.sv -----
// Testbench top: drives requests and configuration into the buddy page allocator and gives the verdict.
`timescale 1ns / 1ps
module testbench;
   import bpa_pkg::*;

   // generous: each init costs a full map clear, and each scan probe costs a read and a check
   localparam int CYCLE_LIMIT = 20_000_000;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;
   int                  fail_count;
   int                  pending;
   int                  checked;

   bpa_req_if req_bus();
   bpa_rsp_if rsp_bus();

   buddy_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bpa_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // idle percentages for the two sides, changed per phase
   int send_pct;
   int recv_pct;
   // long receiver hold: stimulus bumps hold_asked, receiver counts it out
   int hold_asked;
   int hold_seen;
   int hold_left;
   int cycles;
   int alloc_sent;
   int free_sent;
   int init_sent;

   // modes in flight, and heads we believe are allocated (fed from responses)
   logic [MODE_W-1:0]  sent_modes[$];
   logic [PAGE_AW-1:0] owned[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = 400;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   // track allocated heads so that most frees are well formed
   always @(posedge clock) begin
      logic [MODE_W-1:0] m;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sent_modes.push_back(req_bus.mode);
         if (rsp_bus.valid && rsp_bus.ready && sent_modes.size() > 0) begin
            m = sent_modes.pop_front();
            if (m == MODE_INIT) owned.delete();
            else if (m == MODE_ALLOC && rsp_bus.status == STAT_OK)
               owned.push_back(rsp_bus.block_address);
         end
      end
   end

   // write enable drops for a cycle so back-to-back writes never collide
   task automatic csr_write(csr_index_type idx, logic [CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // valid stays high across back-to-back requests; it drops only for a gap
   task automatic send(logic [MODE_W-1:0] mode, logic [COUNT_W-1:0] cnt,
                       logic [PAGE_AW-1:0] addr);
      if ($urandom_range(99) < send_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.mode         <= mode;
      req_bus.page_count   <= cnt;
      req_bus.page_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
      case (mode)
         MODE_ALLOC: alloc_sent++;
         MODE_FREE:  free_sent++;
         MODE_INIT:  init_sent++;
         default: ;
      endcase
   endtask

   // stop offering and wait for every outstanding response
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_item(bit big);
      int                 r;
      int                 i;
      int unsigned        c;
      logic [PAGE_AW-1:0] a;
      r = $urandom_range(99);
      if (r < 45) begin
         // big pools: keep scans short by asking for large blocks
         if (big) c = $urandom_range(33, 1024);
         else begin
            i = $urandom_range(99);
            if (i < 60) c = $urandom_range(1, 8);
            else if (i < 85) c = $urandom_range(9, 128);
            else if (i < 95) c = $urandom_range(129, 1024);
            else if (i < 97) c = 0;
            else c = $urandom_range(1025, 2047);
         end
         send(MODE_ALLOC, c[COUNT_W-1:0], PAGE_AW'($urandom));
      end else if (r < 87 && owned.size() > 0) begin
         i = $urandom_range(owned.size() - 1);
         a = owned[i];
         owned.delete(i);
         if ($urandom_range(99) < 4) a = a + 1'b1;   // usually not a head
         send(MODE_FREE, COUNT_W'($urandom), a);
      end else if (r < 95) begin
         send(MODE_FREE, COUNT_W'($urandom), PAGE_AW'($urandom));
      end else begin
         send(MODE_NONE, COUNT_W'($urandom), PAGE_AW'($urandom));
      end
   endtask

   // reconfigure while idle, rebuild the pool, then random requests
   task automatic run_phase(int tb, int total, int n, bit big, int spct, int rpct);
      drain();
      csr_write(CSR_TOP_BLOCKS, CSR_DW'(tb));
      csr_write(CSR_TOTAL_PAGES, CSR_DW'(total));
      send_pct = spct;
      recv_pct = rpct;
      send(MODE_INIT, COUNT_W'($urandom), PAGE_AW'($urandom));
      repeat (n) random_item(big);
   endtask

   initial begin
      logic [PAGE_AW-1:0] a;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_TOP_BLOCKS;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_NONE;
      req_bus.page_count   = '0;
      req_bus.page_address = '0;
      rsp_bus.ready        = 1'b0;
      send_pct   = 17;
      recv_pct   = 84;
      hold_asked = 0;
      hold_seen  = 0;
      hold_left  = 0;
      cycles     = 0;
      alloc_sent = 0;
      free_sent  = 0;
      init_sent  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: count extremes and rounding, oversize, unused mode, bad and double free
      csr_write(CSR_TOP_BLOCKS, 1);
      csr_write(CSR_TOTAL_PAGES, 2048);
      send(MODE_INIT, 0, 0);
      send(MODE_ALLOC, 0, 0);
      send(MODE_ALLOC, 1, 0);
      send(MODE_ALLOC, 3, 0);
      send(MODE_ALLOC, 1024, 0);
      send(MODE_ALLOC, 1025, 0);
      send(MODE_ALLOC, 11'h7FF, 15'h7FFF);
      send(MODE_NONE, 11'h7FF, 15'h7FFF);
      send(MODE_FREE, 0, 15'h7FFF);
      drain();
      if (owned.size() > 0) begin
         a = owned[0];
         send(MODE_FREE, 0, a + 1'b1);
         send(MODE_FREE, 0, a);
         send(MODE_FREE, 0, a);
         void'(owned.pop_front());
      end
      // freeing the 1024-page block exercises the merge cap
      while (owned.size() > 0) send(MODE_FREE, 0, owned.pop_front());

      // sender mostly busy, receiver mostly stalled
      run_phase(0, 1, 20, 0, 17, 84);
      run_phase(3, 1024, 300, 0, 17, 84);
      // the other way round, with one long receiver hold mid-phase
      run_phase(2, 900, 120, 0, 84, 17);
      hold_asked++;
      repeat (130) random_item(0);
      run_phase(3, 32768, 10, 1, 84, 17);
      // no idling; sender waits for a full drain once
      run_phase(0, 640, 150, 0, 0, 0);
      drain();
      repeat (150) random_item(0);
      run_phase(2, 31929, 10, 1, 0, 0);
      run_phase(1, 1024, 200, 0, 0, 0);
      run_phase(3, 500, 150, 0, 0, 0);

      drain();
      repeat (100) @(posedge clock);
      $display("summary: %0d responses checked (%0d alloc, %0d free, %0d init requests)",
               checked, alloc_sent, free_sent, init_sent);
      $display("summary: pools from 1 to 32768 pages, regions of 0 to 3 units, three idle mixes");
      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_dp.sv
rtl/bpa_ctrl.sv
rtl/buddy_page_allocator.sv
bench/bpa_checker.sv
bench/testbench.sv
